// ===== rtl/pica_pkg.sv =====
// Shared types and constants for the point-in-cylinder-annulus unit.
// Depends on nothing; pica_front, pica_back and the top level import it.
package pica_pkg;

	// field widths
	localparam int INDEX_BITS   = 24;
	localparam int COORD_BITS   = 24;
	localparam int REG_IDX_BITS = 3;

	// derived datapath widths
	localparam int DIFF_BITS    = COORD_BITS + 1;     // centre - base, tip - base
	localparam int PROD_BITS    = 2 * DIFF_BITS;      // one coordinate product
	localparam int SUM_BITS     = PROD_BITS + 2;      // sum of three products
	localparam int RAD_BITS     = COORD_BITS - 1;     // unsigned radius
	localparam int RAD_SQ_BITS  = 2 * RAD_BITS;       // radius squared
	localparam int LHS_BITS     = 2 * SUM_BITS;       // |d|^2*|a|^2 and (d.a)^2
	localparam int LIM_BITS     = RAD_SQ_BITS + SUM_BITS; // r^2*|a|^2

	// configuration register indexes
	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_BASE_X,
		REG_BASE_Y,
		REG_BASE_Z,
		REG_TIP_X,
		REG_TIP_Y,
		REG_TIP_Z,
		REG_OUTER,
		REG_INNER
	} reg_idx_t;

	// one input item
	typedef struct packed {
		logic [INDEX_BITS-1:0]        cell_index;
		logic signed [COORD_BITS-1:0] centre_x;
		logic signed [COORD_BITS-1:0] centre_y;
		logic signed [COORD_BITS-1:0] centre_z;
		logic                         action;
	} query_t;

	// one result item
	typedef struct packed {
		logic [INDEX_BITS-1:0] cell_id;
		logic                  hit;
		logic                  member_value;
	} result_t;

	// sideband that travels with each item down the pipeline
	typedef struct packed {
		logic valid;
		logic action;
		logic win;     // projection lies strictly between the end planes
	} ctl_t;

endpackage

// ===== rtl/pica_front.sv =====
// Front end of the annulus pipeline: differences, coordinate products and sums.
// Stages s1..s3. Depends on pica_pkg.
module pica_front (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    valid,
	input  pica_pkg::query_t                        query,
	input  logic signed [pica_pkg::COORD_BITS-1:0]  base_x,
	input  logic signed [pica_pkg::COORD_BITS-1:0]  base_y,
	input  logic signed [pica_pkg::COORD_BITS-1:0]  base_z,
	input  logic signed [pica_pkg::COORD_BITS-1:0]  tip_x,
	input  logic signed [pica_pkg::COORD_BITS-1:0]  tip_y,
	input  logic signed [pica_pkg::COORD_BITS-1:0]  tip_z,
	input  logic [pica_pkg::RAD_BITS-1:0]           outer_radius,
	input  logic [pica_pkg::RAD_BITS-1:0]           inner_radius,
	output pica_pkg::ctl_t                          ctl_s3,
	output logic [pica_pkg::INDEX_BITS-1:0]         id_s3,
	output logic signed [pica_pkg::SUM_BITS-1:0]    dot_s3,
	output logic signed [pica_pkg::SUM_BITS-1:0]    dd_s3,
	output logic signed [pica_pkg::SUM_BITS-1:0]    aa_s3,
	output logic [pica_pkg::RAD_SQ_BITS-1:0]        ro2_s3,
	output logic [pica_pkg::RAD_SQ_BITS-1:0]        ri2_s3
);
	import pica_pkg::*;

	logic signed [COORD_BITS-1:0] cen  [3];
	logic signed [COORD_BITS-1:0] base [3];
	logic signed [COORD_BITS-1:0] tip  [3];

	ctl_t                   ctl_s1, ctl_s2;
	logic [INDEX_BITS-1:0]  id_s1, id_s2;
	logic signed [DIFF_BITS-1:0] d_s1 [3];
	logic signed [DIFF_BITS-1:0] a_s1 [3];
	logic signed [PROD_BITS-1:0] da_s2 [3];
	logic signed [PROD_BITS-1:0] dd_s2 [3];
	logic signed [PROD_BITS-1:0] aa_s2 [3];
	logic [RAD_SQ_BITS-1:0] ro2_s2, ri2_s2;

	assign cen[0]  = query.centre_x;
	assign cen[1]  = query.centre_y;
	assign cen[2]  = query.centre_z;
	assign base[0] = base_x;
	assign base[1] = base_y;
	assign base[2] = base_z;
	assign tip[0]  = tip_x;
	assign tip[1]  = tip_y;
	assign tip[2]  = tip_z;

	// sideband valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s1 <= '{valid: valid, action: query.action, win: 1'b0};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// s1: offsets from the base point
	always_ff @(posedge clk) begin
		id_s1 <= query.cell_index;
		for (int k = 0; k < 3; k++) begin
			d_s1[k] <= DIFF_BITS'(cen[k]) - DIFF_BITS'(base[k]);
			a_s1[k] <= DIFF_BITS'(tip[k]) - DIFF_BITS'(base[k]);
		end
	end

	// s2: per-axis products and squared radii
	always_ff @(posedge clk) begin
		id_s2  <= id_s1;
		ro2_s2 <= RAD_SQ_BITS'(outer_radius) * RAD_SQ_BITS'(outer_radius);
		ri2_s2 <= RAD_SQ_BITS'(inner_radius) * RAD_SQ_BITS'(inner_radius);
		for (int k = 0; k < 3; k++) begin
			da_s2[k] <= PROD_BITS'(d_s1[k]) * PROD_BITS'(a_s1[k]);
			dd_s2[k] <= PROD_BITS'(d_s1[k]) * PROD_BITS'(d_s1[k]);
			aa_s2[k] <= PROD_BITS'(a_s1[k]) * PROD_BITS'(a_s1[k]);
		end
	end

	// s3: d.a, |d|^2, |a|^2
	always_ff @(posedge clk) begin
		id_s3  <= id_s2;
		ro2_s3 <= ro2_s2;
		ri2_s3 <= ri2_s2;
		dot_s3 <= SUM_BITS'(da_s2[0]) + SUM_BITS'(da_s2[1]) + SUM_BITS'(da_s2[2]);
		dd_s3  <= SUM_BITS'(dd_s2[0]) + SUM_BITS'(dd_s2[1]) + SUM_BITS'(dd_s2[2]);
		aa_s3  <= SUM_BITS'(aa_s2[0]) + SUM_BITS'(aa_s2[1]) + SUM_BITS'(aa_s2[2]);
	end

endmodule

// ===== rtl/pica_wide_mul.sv =====
// Two-stage unsigned multiplier built from four half-width partial products.
// Stage s4 registers the partials, s5 the summed product. Depends on nothing.
module pica_wide_mul #(
	parameter int WA = 52,
	parameter int WB = 52
) (
	input  logic             clk,
	input  logic [WA-1:0]    a,
	input  logic [WB-1:0]    b,
	output logic [WA+WB-1:0] p
);
	localparam int LA = (WA + 1) / 2;
	localparam int UA = WA - LA;
	localparam int LB = (WB + 1) / 2;
	localparam int UB = WB - LB;
	localparam int PW = WA + WB;

	logic [LA+LB-1:0] ll_s4;
	logic [LA+UB-1:0] lh_s4;
	logic [UA+LB-1:0] hl_s4;
	logic [UA+UB-1:0] hh_s4;

	// s4: partial products of the operand halves
	always_ff @(posedge clk) begin
		ll_s4 <= (LA+LB)'(a[LA-1:0])  * (LA+LB)'(b[LB-1:0]);
		lh_s4 <= (LA+UB)'(a[LA-1:0])  * (LA+UB)'(b[WB-1:LB]);
		hl_s4 <= (UA+LB)'(a[WA-1:LA]) * (UA+LB)'(b[LB-1:0]);
		hh_s4 <= (UA+UB)'(a[WA-1:LA]) * (UA+UB)'(b[WB-1:LB]);
	end

	// s5: shift and add
	always_ff @(posedge clk) begin
		p <= PW'(ll_s4)
			+ (PW'(lh_s4) << LB)
			+ (PW'(hl_s4) << LA)
			+ (PW'(hh_s4) << (LA + LB));
	end

endmodule

// ===== rtl/pica_back.sv =====
// Back end of the annulus pipeline: radial distance term and final compares.
// Stages s6..s7, drives the result ports. Depends on pica_pkg.
module pica_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pica_pkg::ctl_t                    ctl_s5,
	input  logic [pica_pkg::INDEX_BITS-1:0]   id_s5,
	input  logic [pica_pkg::LHS_BITS-1:0]     ddaa,
	input  logic [pica_pkg::LHS_BITS-3:0]     dotdot,
	input  logic [pica_pkg::LIM_BITS-1:0]     olim,
	input  logic [pica_pkg::LIM_BITS-1:0]     ilim,
	output logic                              done,
	output pica_pkg::result_t                 result
);
	import pica_pkg::*;

	ctl_t                  ctl_s6;
	logic [INDEX_BITS-1:0] id_s6;
	logic [LHS_BITS-1:0]   lhs_s6;
	logic [LIM_BITS-1:0]   olim_s6, ilim_s6;
	logic                  done_s7;
	result_t               result_s7;
	logic                  hit;

	// control chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6  <= '0;
			done_s7 <= 1'b0;
		end else begin
			ctl_s6  <= ctl_s5;
			done_s7 <= ctl_s6.valid;
		end
	end

	// s6: squared distance from the axis, scaled by |a|^2 (never negative)
	always_ff @(posedge clk) begin
		id_s6   <= id_s5;
		lhs_s6  <= ddaa - LHS_BITS'(dotdot);
		olim_s6 <= olim;
		ilim_s6 <= ilim;
	end

	// strictly inside the outer radius, strictly outside the inner radius and between the end planes
	assign hit = ctl_s6.win
		&& (lhs_s6 < LHS_BITS'(olim_s6))
		&& (lhs_s6 > LHS_BITS'(ilim_s6));

	// s7: result register
	always_ff @(posedge clk) begin
		result_s7.cell_id      <= id_s6;
		result_s7.hit          <= hit;
		result_s7.member_value <= hit & ~ctl_s6.action;
	end

	assign done   = done_s7;
	assign result = result_s7;

endmodule

// ===== rtl/point_in_cylinder_annulus_unit.sv =====
// Top level of the point-in-cylinder-annulus unit.
// Depends on pica_pkg, pica_front, pica_wide_mul and pica_back.
//
// Usage:
//   Write the axis end points and the two radii through cfg_we / cfg_addr /
//   cfg_wdata while no item is in flight; a write takes effect at the edge.
//   An item (cell index, centre, action) is taken at each rising edge with
//   start high and busy low. busy is held low: the pipeline takes one item
//   every cycle with no gaps.
//   Each item gives exactly one result: done is high for one cycle and result
//   carries cell_id, hit and member_value. Each result is registered through
//   stages s1 to s7 in turn; results leave in the order the items came in.
//   Throughput is one item per cycle; the depth is set by the two-stage
//   split multipliers that form the 98- to 104-bit products.
//   The receiver has no back-pressure: a result is valid for its one cycle.
//   Reset clears the configuration registers to zero and drops every item
//   in flight; the result payload is not cleared.
module point_in_cylinder_annulus_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  pica_pkg::query_t                     query,
	output logic                                 done,
	output pica_pkg::result_t                    result,
	input  logic                                 cfg_we,
	input  logic [pica_pkg::REG_IDX_BITS-1:0]    cfg_addr,
	input  logic [pica_pkg::COORD_BITS-1:0]      cfg_wdata
);
	import pica_pkg::*;

	localparam int DEPTH = 7;

	logic signed [COORD_BITS-1:0] base_x_q, base_y_q, base_z_q;
	logic signed [COORD_BITS-1:0] tip_x_q, tip_y_q, tip_z_q;
	logic [RAD_BITS-1:0]          outer_q, inner_q;

	logic                         accept;
	ctl_t                         ctl_s3, ctl_s4, ctl_s5;
	logic [INDEX_BITS-1:0]        id_s3, id_s4, id_s5;
	logic signed [SUM_BITS-1:0]   dot_s3, dd_s3, aa_s3;
	logic [RAD_SQ_BITS-1:0]       ro2_s3, ri2_s3;
	logic                         win;
	logic [LHS_BITS-1:0]          ddaa_s5;
	logic [LHS_BITS-3:0]          dotdot_s5;
	logic [LIM_BITS-1:0]          olim_s5, ilim_s5;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_x_q <= '0;
			base_y_q <= '0;
			base_z_q <= '0;
			tip_x_q  <= '0;
			tip_y_q  <= '0;
			tip_z_q  <= '0;
			outer_q  <= '0;
			inner_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BASE_X: base_x_q <= cfg_wdata;
				REG_BASE_Y: base_y_q <= cfg_wdata;
				REG_BASE_Z: base_z_q <= cfg_wdata;
				REG_TIP_X:  tip_x_q  <= cfg_wdata;
				REG_TIP_Y:  tip_y_q  <= cfg_wdata;
				REG_TIP_Z:  tip_z_q  <= cfg_wdata;
				REG_OUTER:  outer_q  <= cfg_wdata[RAD_BITS-1:0];
				REG_INNER:  inner_q  <= cfg_wdata[RAD_BITS-1:0];
			endcase
		end
	end

	// s1..s3: offsets, products, dot and squared lengths
	pica_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (accept),
		.query        (query),
		.base_x       (base_x_q),
		.base_y       (base_y_q),
		.base_z       (base_z_q),
		.tip_x        (tip_x_q),
		.tip_y        (tip_y_q),
		.tip_z        (tip_z_q),
		.outer_radius (outer_q),
		.inner_radius (inner_q),
		.ctl_s3       (ctl_s3),
		.id_s3        (id_s3),
		.dot_s3       (dot_s3),
		.dd_s3        (dd_s3),
		.aa_s3        (aa_s3),
		.ro2_s3       (ro2_s3),
		.ri2_s3       (ri2_s3)
	);

	// projection window: 0 < d.a < |a|^2 (empty for a zero axis)
	assign win = !dot_s3[SUM_BITS-1] && (dot_s3 != '0) && (dot_s3 < aa_s3);

	// sideband across the multiplier stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s4 <= '{valid: ctl_s3.valid, action: ctl_s3.action, win: win};
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		id_s4 <= id_s3;
		id_s5 <= id_s4;
	end

	// s4..s5: wide products; d.a only matters when positive, so its magnitude
	// bits are squared as unsigned
	pica_wide_mul #(.WA(SUM_BITS), .WB(SUM_BITS)) u_mul_ddaa (
		.clk (clk),
		.a   (dd_s3),
		.b   (aa_s3),
		.p   (ddaa_s5)
	);

	pica_wide_mul #(.WA(SUM_BITS-1), .WB(SUM_BITS-1)) u_mul_dot (
		.clk (clk),
		.a   (dot_s3[SUM_BITS-2:0]),
		.b   (dot_s3[SUM_BITS-2:0]),
		.p   (dotdot_s5)
	);

	pica_wide_mul #(.WA(RAD_SQ_BITS), .WB(SUM_BITS)) u_mul_olim (
		.clk (clk),
		.a   (ro2_s3),
		.b   (aa_s3),
		.p   (olim_s5)
	);

	pica_wide_mul #(.WA(RAD_SQ_BITS), .WB(SUM_BITS)) u_mul_ilim (
		.clk (clk),
		.a   (ri2_s3),
		.b   (aa_s3),
		.p   (ilim_s5)
	);

	// s6..s7: radial compare and result register
	pica_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s5 (ctl_s5),
		.id_s5  (id_s5),
		.ddaa   (ddaa_s5),
		.dotdot (dotdot_s5),
		.olim   (olim_s5),
		.ilim   (ilim_s5),
		.done   (done),
		.result (result)
	);

	// every result traces back to an accepted item
	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, DEPTH))
		else $error("result without a matching item");

	a_id_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.cell_id == $past(query.cell_index, DEPTH))
		else $error("cell id does not match its item");

	a_member_action: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.hit |-> result.member_value == !$past(query.action, DEPTH))
		else $error("member value does not follow the action");

	a_hit_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.hit |-> $past(ctl_s5.win, 2))
		else $error("hit outside the projection window");

endmodule
